[hdl/assert_macros.svh]
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property that also holds through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[hdl/rbrc_pkg.sv]
package rbrc_pkg;

  localparam int COUNT_BITS     = 40;
  localparam int END_BITS       = 32;
  localparam int LEFT_BITS      = 32;
  localparam int CODE_BITS      = 8;
  localparam int GROUP_BITS     = 7;
  localparam int MAX_EXT_BYTES  = 5;
  localparam int EXT_IDX_BITS   = 3;
  // Longest run: 63 from the escape code plus MAX_EXT_BYTES groups of 7 bits.
  localparam int RUN_BITS       = 36;
  localparam int SYM_BITS       = 3;

  localparam int RUN_SPAN       = 63;
  localparam int FIRST_END_CODE = 252;
  localparam int ESC_END_CODE   = 255;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [SYM_BITS-1:0] SYM_A   = 3'd0;
  localparam logic [SYM_BITS-1:0] SYM_C   = 3'd1;
  localparam logic [SYM_BITS-1:0] SYM_G   = 3'd2;
  localparam logic [SYM_BITS-1:0] SYM_T   = 3'd3;
  localparam logic [SYM_BITS-1:0] SYM_END = 3'd4;

  typedef struct packed {
    logic                  kind;
    logic [COUNT_BITS-1:0] base_count_a;
    logic [COUNT_BITS-1:0] base_count_c;
    logic [COUNT_BITS-1:0] base_count_g;
    logic [COUNT_BITS-1:0] base_count_t;
    logic [END_BITS-1:0]   base_count_end;
    logic [LEFT_BITS-1:0]  symbols_left;
    logic [CODE_BITS-1:0]  code_byte;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] rank_a;
    logic [COUNT_BITS-1:0] rank_c;
    logic [COUNT_BITS-1:0] rank_g;
    logic [COUNT_BITS-1:0] rank_t;
    logic [END_BITS-1:0]   rank_end;
  } out_t;

  // Decoded view of one code byte, both as a leading code and as an extension.
  typedef struct packed {
    logic [SYM_BITS-1:0] sym;
    logic [RUN_BITS-1:0] first_run;
    logic                escape;
    logic [RUN_BITS-1:0] ext_run;
    logic                ext_last;
  } dec_t;

endpackage

[hdl/rle_bwt_rank_counter.sv]
// Accepted words wait in the input register; results go to the output register.
// Throughput: one input word per cycle; the single-pass update of the counters sets it.
// The input stalls only while a result word sits in the output register and is stalled.
// Reset (rst_ni low, asynchronous): counters, remaining count and decoder phase clear,
// decoder goes idle, both word registers empty.
module rle_bwt_rank_counter
  import rbrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_word_o
);

  // Input register: one word in flight ahead of the counter update.
  logic in_vq_q, in_vq_d;
  in_t  in_q;

  // Output register: holds a finished result until taken.
  logic out_vq_q, out_vq_d;
  out_t out_q;

  logic accept;
  logic go;       // the word in the input register is consumed this cycle
  logic res_valid;
  out_t res;

  // A word may be consumed whenever the output register can take a result.
  // Results are rare, but keeping the condition uniform keeps ordering trivial.
  assign go         = in_vq_q && (!out_vq_q || !out_stall_i);
  assign in_stall_o = in_vq_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  rbrc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .word_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_vq_d = in_vq_q;
    if (accept) begin
      in_vq_d = 1'b1;
    end else if (go) begin
      in_vq_d = 1'b0;
    end

    out_vq_d = out_vq_q;
    if (go && res_valid) begin
      out_vq_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vq_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq_q  <= 1'b0;
      out_vq_q <= 1'b0;
    end else begin
      in_vq_q  <= in_vq_d;
      out_vq_q <= out_vq_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (go && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vq_q;
  assign out_word_o  = out_q;

endmodule

[hdl/rbrc_decode.sv]
module rbrc_decode
  import rbrc_pkg::*;
(
  input  logic [CODE_BITS-1:0]    code_i,
  input  logic [RUN_BITS-1:0]     run_acc_i,
  input  logic [EXT_IDX_BITS-1:0] ext_idx_i,
  output dec_t                    dec_o
);

  logic [CODE_BITS-1:0] rem;
  logic [RUN_BITS-1:0]  grp;

  always_comb begin
    dec_o = '0;
    rem   = '0;
    // code / 63 and code % 63 by compare against the four boundaries
    priority if (code_i >= CODE_BITS'(FIRST_END_CODE)) begin
      dec_o.sym       = SYM_END;
      dec_o.first_run = RUN_BITS'(code_i - CODE_BITS'(FIRST_END_CODE - 1));
      dec_o.escape    = (code_i == CODE_BITS'(ESC_END_CODE));
    end else begin
      priority if (code_i >= CODE_BITS'(3 * RUN_SPAN)) begin
        dec_o.sym = SYM_T;
        rem       = code_i - CODE_BITS'(3 * RUN_SPAN);
      end else if (code_i >= CODE_BITS'(2 * RUN_SPAN)) begin
        dec_o.sym = SYM_G;
        rem       = code_i - CODE_BITS'(2 * RUN_SPAN);
      end else if (code_i >= CODE_BITS'(RUN_SPAN)) begin
        dec_o.sym = SYM_C;
        rem       = code_i - CODE_BITS'(RUN_SPAN);
      end else begin
        dec_o.sym = SYM_A;
        rem       = code_i;
      end
      dec_o.first_run = RUN_BITS'(rem) + RUN_BITS'(1);
      dec_o.escape    = (rem == CODE_BITS'(RUN_SPAN - 1));
    end

    // extension byte: 7-bit group, little-endian
    grp           = RUN_BITS'(code_i[GROUP_BITS-1:0]);
    dec_o.ext_run = run_acc_i + (grp << (ext_idx_i * GROUP_BITS));
    dec_o.ext_last = !code_i[CODE_BITS-1] ||
                     (ext_idx_i >= EXT_IDX_BITS'(MAX_EXT_BYTES - 1));
  end

endmodule

[hdl/rbrc_accum.sv]
module rbrc_accum
  import rbrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic go_i,
  input  in_t  word_i,
  output logic res_valid_o,
  output out_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CODE,
    PH_EXT
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [COUNT_BITS-1:0]   cnt_q [4];
  logic [COUNT_BITS-1:0]   cnt_d [4];
  logic [END_BITS-1:0]     end_q, end_d;
  logic [LEFT_BITS-1:0]    left_q, left_d;
  logic [SYM_BITS-1:0]     sym_q, sym_d;
  logic [RUN_BITS-1:0]     run_q, run_d;
  logic [EXT_IDX_BITS-1:0] idx_q, idx_d;

  dec_t                    dec;
  logic                    fin;
  logic [SYM_BITS-1:0]     fin_sym;
  logic [RUN_BITS-1:0]     fin_run;
  logic [LEFT_BITS-1:0]    clip;
  logic [COUNT_BITS:0]     cnt_sum;
  logic [END_BITS:0]       end_sum;

  rbrc_decode u_decode (
    .code_i    (word_i.code_byte),
    .run_acc_i (run_q),
    .ext_idx_i (idx_q),
    .dec_o     (dec)
  );

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    left_d      = left_q;
    sym_d       = sym_q;
    run_d       = run_q;
    idx_d       = idx_q;
    res_valid_o = 1'b0;
    fin         = 1'b0;
    fin_sym     = sym_q;
    fin_run     = run_q;
    clip        = '0;
    cnt_sum     = '0;
    end_sum     = '0;

    if (go_i) begin
      if (word_i.kind == KIND_START) begin
        cnt_d[0] = word_i.base_count_a;
        cnt_d[1] = word_i.base_count_c;
        cnt_d[2] = word_i.base_count_g;
        cnt_d[3] = word_i.base_count_t;
        end_d    = word_i.base_count_end;
        left_d   = word_i.symbols_left;
        sym_d    = SYM_A;
        run_d    = '0;
        idx_d    = '0;
        if (word_i.symbols_left == '0) begin
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
        end else begin
          phase_d = PH_CODE;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            // stray byte, dropped
          end
          PH_CODE: begin
            sym_d = dec.sym;
            run_d = dec.first_run;
            idx_d = '0;
            if (dec.escape) begin
              phase_d = PH_EXT;
            end else begin
              fin     = 1'b1;
              fin_sym = dec.sym;
              fin_run = dec.first_run;
            end
          end
          PH_EXT: begin
            run_d = dec.ext_run;
            idx_d = idx_q + EXT_IDX_BITS'(1);
            if (dec.ext_last) begin
              fin     = 1'b1;
              fin_run = dec.ext_run;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end

    if (fin) begin
      // clip to what is left, then saturating add
      clip = (fin_run > RUN_BITS'(left_q)) ? left_q : fin_run[LEFT_BITS-1:0];
      if (fin_sym == SYM_END) begin
        end_sum = {1'b0, end_q} + (END_BITS + 1)'(clip);
        end_d   = end_sum[END_BITS] ? '1 : end_sum[END_BITS-1:0];
      end else begin
        cnt_sum = {1'b0, cnt_q[fin_sym[1:0]]} + (COUNT_BITS + 1)'(clip);
        cnt_d[fin_sym[1:0]] = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
      end
      left_d = left_q - clip;
      run_d  = '0;
      idx_d  = '0;
      if (left_d == '0) begin
        res_valid_o = 1'b1;
        phase_d     = PH_IDLE;
      end else begin
        phase_d = PH_CODE;
      end
    end

    res_o.rank_a   = cnt_d[0];
    res_o.rank_c   = cnt_d[1];
    res_o.rank_g   = cnt_d[2];
    res_o.rank_t   = cnt_d[3];
    res_o.rank_end = end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '{default: '0};
      end_q   <= '0;
      left_q  <= '0;
      sym_q   <= '0;
      run_q   <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
      left_q  <= left_d;
      sym_q   <= sym_d;
      run_q   <= run_d;
      idx_q   <= idx_d;
    end
  end

endmodule

[hdl/rbrc_checker.sv]
`include "assert_macros.svh"

module rbrc_checker
  import rbrc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_word_o
);

  // result word holds while stalled
  `ASSERT_CLK(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `ASSERT_CLK(a_out_word_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_word_o))

  // input backpressure only comes from a blocked result word
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)

  // no result word appears right out of reset
  `ASSERT_CLK_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind rle_bwt_rank_counter rbrc_checker u_rbrc_checker (.*);
